// ----- hdl/suks_pkg.sv -----
package suks_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 31;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 7;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    localparam logic REG_MIN_KEY = 1'b0;
    localparam logic REG_MAX_KEY = 1'b1;

    // update broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

// ----- hdl/suks_cell.sv -----
module suks_cell import suks_pkg::*; (
    input  logic             i_clk,
    input  logic             i_cmp_en,
    input  logic [KEY_W-1:0] i_cmp_key,
    input  logic             i_occ,
    input  t_cell_ctl        i_ctl,
    input  logic             i_prev_lt,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [KEY_W-1:0] i_next_key,
    output logic [KEY_W-1:0] o_key,
    output logic             o_lt,
    output logic             o_eq
);

    logic [KEY_W-1:0] r_key;
    logic             r_lt;
    logic             r_eq;

    // compare against the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_lt <= i_occ && (r_key < i_cmp_key);
            r_eq <= i_occ && (r_key == i_cmp_key);
        end
    end

    // open a slot or close the gap; cells below the position keep their key
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_prev_lt ? i_ctl.key : i_prev_key;
        end else if (i_ctl.rem && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

// ----- hdl/suks_chain.sv -----
module suks_chain import suks_pkg::*; (
    input  logic                i_clk,
    input  logic                i_cmp_en,
    input  logic [KEY_W-1:0]    i_cmp_key,
    input  logic [CNT_W-1:0]    i_count,
    input  t_cell_ctl           i_ctl,
    output logic                o_present
);

    logic [KEY_W-1:0]    w_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic             w_occ;
        logic             w_prev_lt;
        logic [KEY_W-1:0] w_prev_key;
        logic [KEY_W-1:0] w_next_key;

        assign w_occ = CNT_W'(i) < i_count;

        if (i == 0) begin : g_head
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = i_ctl.key;
        end else begin : g_body
            assign w_prev_lt  = w_lt[i-1];
            assign w_prev_key = w_key[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next_key = w_key[i];
        end else begin : g_mid
            assign w_next_key = w_key[i+1];
        end

        suks_cell u_cell (
            .i_clk      (i_clk),
            .i_cmp_en   (i_cmp_en),
            .i_cmp_key  (i_cmp_key),
            .i_occ      (w_occ),
            .i_ctl      (i_ctl),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_next_key (w_next_key),
            .o_key      (w_key[i]),
            .o_lt       (w_lt[i]),
            .o_eq       (w_eq[i])
        );
    end

    assign o_present = |w_eq;

endmodule

// ----- hdl/sorted_unique_key_set_core.sv -----
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_command, i_key
// result    out        o_out_valid / i_out_ready  o_status, o_entry_count
// config    in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// every cell compares its key on the accept edge; the decide cycle then settles
// the status and shifts the chain in one step
// the status decision ORs the per-cell equal flags across the whole chain
// the result sits in an output register, so a new word is taken while it waits
// a stalled result holds the chain in the decide cycle until it drains
// synchronous active-low reset empties the set and restores the key range
module sorted_unique_key_set_core import suks_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [KEY_W-1:0]    i_key,
    // results
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ENTRY_W-1:0]  o_entry_count,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // key range registers
    logic [KEY_W-1:0] r_min_key;
    logic [KEY_W-1:0] r_max_key;

    // word under work
    logic             r_busy;
    logic             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic             r_range_bad;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [ENTRY_W-1:0]  r_entry_count;

    logic                     w_accept;
    logic                     w_apply;
    logic                     w_present;
    logic                     w_full;
    logic                     w_cfg_wr;
    t_cell_ctl                w_ctl;
    logic [CNT_W+ENTRY_W-1:0] w_count_ext;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // register index sits in address bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_key <= '0;
            r_max_key <= '1;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_KEY: r_min_key <= pwdata[KEY_W-1:0];
                REG_MAX_KEY: r_max_key <= pwdata[KEY_W-1:0];
                default:     r_min_key <= r_min_key;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_KEY: prdata = {{(DATA_W-KEY_W){1'b0}}, r_min_key};
            REG_MAX_KEY: prdata = {{(DATA_W-KEY_W){1'b0}}, r_max_key};
            default:     prdata = '0;
        endcase
    end

    // one word at a time; decide only when the result register can take it
    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_apply    = r_busy && (!r_out_valid || i_out_ready);
    assign w_full     = r_count == CNT_W'(CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_apply) begin
            r_busy <= 1'b0;
        end
    end

    // range check is done on the accept edge, alongside the cell compares
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_command;
            r_key       <= i_key;
            r_range_bad <= (i_key < r_min_key) || (i_key > r_max_key);
        end
    end

    // status decision for inserts: range, then presence, then full; removes check presence only
    always_comb begin
        w_ctl.ins = 1'b0;
        w_ctl.rem = 1'b0;
        w_ctl.key = r_key;
        n_count   = r_count;
        n_status  = ST_OK;
        if (r_cmd == CMD_INSERT) begin
            if (r_range_bad) begin
                n_status = ST_RANGE;
            end else if (w_present) begin
                n_status = ST_PRESENT;
            end else if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.ins = w_apply;
                n_count   = r_count + 1'b1;
            end
        end else begin
            if (w_present) begin
                w_ctl.rem = w_apply;
                n_count   = r_count - 1'b1;
            end else begin
                n_status = ST_ABSENT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_apply) begin
            r_count <= n_count;
        end
    end

    suks_chain u_chain (
        .i_clk     (i_clk),
        .i_cmp_en  (w_accept),
        .i_cmp_key (i_key),
        .i_count   (r_count),
        .i_ctl     (w_ctl),
        .o_present (w_present)
    );

    // reported count is the count after this word's update
    assign w_count_ext = {{ENTRY_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_status      <= n_status;
            r_entry_count <= w_count_ext[ENTRY_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

endmodule

// ----- hdl/suks_checker.sv -----
module suks_checker import suks_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic [ENTRY_W-1:0]  o_entry_count
);

    // a stalled result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // one word at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");

    // a fresh result only comes out of the decide cycle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without a word in work");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_RANGE ||
                         o_status == ST_PRESENT || o_status == ST_ABSENT ||
                         o_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind sorted_unique_key_set_core suks_checker u_suks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
